/* sv/quaternion_slerp_defines.svh */
// Assertion macros shared by the quaternion slerp RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef QUATERNION_SLERP_DEFINES_SVH
`define QUATERNION_SLERP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication check.
`define QS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion_slerp: same-cycle check failed");
// Next-cycle implication check.
`define QS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quaternion_slerp: next-cycle check failed");
`else
`define QS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define QS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* sv/qs_pkg.sv */
`default_nettype none

package qs_pkg;

   // Angles are unsigned with pi = 65536.
   localparam logic [16:0] ANG_PI   = 17'd65536;
   localparam logic [16:0] ANG_HALF = 17'd32768;

   // Weight of one in unsigned Q1.15.
   localparam logic [15:0] T_ONE = 16'd32768;

   // One in Q.30 and pi in Q.30 radians.
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [31:0] SIN_PI  = 32'd3373259426;

   // Sine evaluator: five nested polynomial terms, 13 register stages.
   localparam int SIN_TERMS = 5;
   localparam int SIN_LAT   = 13;

   // Exact floor division by 110, 72, 42, 20 and 6 for 32-bit dividends:
   // multiply by ceil(2^(32+l)/d) and shift right by 32+l, with 2^l >= d.
   localparam logic [32:0] SIN_RECIP [SIN_TERMS] = '{
      33'(((65'd1 << 39) + 65'd109) / 65'd110),
      33'(((65'd1 << 39) + 65'd71) / 65'd72),
      33'(((65'd1 << 38) + 65'd41) / 65'd42),
      33'(((65'd1 << 37) + 65'd19) / 65'd20),
      33'(((65'd1 << 35) + 65'd5) / 65'd6)
   };
   localparam int SIN_SHIFT [SIN_TERMS] = '{39, 39, 38, 37, 35};

   // Arc cosine bit search and divider depth.
   localparam int ACOS_STEPS = 17;
   localparam int DIV_STEPS  = 17;

endpackage

`default_nettype wire

/* sv/qs_sin.sv */
`default_nettype none

module qs_sin (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [16:0] angle,
   output logic [30:0]      sine
);

   logic [16:0] clamp_a;
   logic [15:0] fold_a;
   logic [47:0] x_prod;
   logic [31:0] x0_ff;
   logic [63:0] sq_prod;
   logic [31:0] x1_ff;
   logic [31:0] x2s_ff;
   logic [31:0] xa_ff  [qs_pkg::SIN_TERMS];
   logic [31:0] x2a_ff [qs_pkg::SIN_TERMS];
   logic [31:0] v_ff   [qs_pkg::SIN_TERMS];
   logic [31:0] xb_ff  [qs_pkg::SIN_TERMS];
   logic [31:0] x2b_ff [qs_pkg::SIN_TERMS];
   logic [30:0] h_ff   [qs_pkg::SIN_TERMS];
   logic [62:0] fin_prod;
   logic [30:0] sine_ff;

   // Clamp to pi, fold onto [0, pi/2] and scale to Q.30 radians.
   always_comb begin
      clamp_a = (angle > qs_pkg::ANG_PI) ? qs_pkg::ANG_PI : angle;
      fold_a  = 16'((clamp_a > qs_pkg::ANG_HALF) ? (qs_pkg::ANG_PI - clamp_a) : clamp_a);
      x_prod  = 48'(fold_a) * 48'(qs_pkg::SIN_PI);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x0_ff <= x_prod[47:16];
      end
   end

   // Square of the angle in Q.30.
   assign sq_prod = 64'(x0_ff) * 64'(x0_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff  <= x0_ff;
         x2s_ff <= sq_prod[61:30];
      end
   end

   // Nested Horner terms, two stages each: product, then exact division.
   for (genvar j = 0; j < qs_pkg::SIN_TERMS; j++) begin : g_term
      logic [31:0] x_src;
      logic [31:0] x2_src;
      logic [30:0] h_src;
      logic [62:0] v_prod;
      logic [64:0] d_prod;
      logic [32:0] tmp;
      logic [30:0] h_in;

      if (j == 0) begin : g_first
         assign x_src  = x1_ff;
         assign x2_src = x2s_ff;
         assign h_src  = qs_pkg::ONE_Q30;
      end else begin : g_next
         assign x_src  = xb_ff[j-1];
         assign x2_src = x2b_ff[j-1];
         assign h_src  = h_ff[j-1];
      end

      assign v_prod = 63'(x2_src) * 63'(h_src);
      assign d_prod = 65'(v_ff[j]) * 65'(qs_pkg::SIN_RECIP[j]);
      assign tmp    = 33'(d_prod >> qs_pkg::SIN_SHIFT[j]);
      assign h_in   = (tmp > 33'(qs_pkg::ONE_Q30)) ? '0 :
                      31'(33'(qs_pkg::ONE_Q30) - tmp);

      always_ff @(posedge clock) begin
         if (enable) begin
            xa_ff[j]  <= x_src;
            x2a_ff[j] <= x2_src;
            v_ff[j]   <= v_prod[61:30];
            xb_ff[j]  <= xa_ff[j];
            x2b_ff[j] <= x2a_ff[j];
            h_ff[j]   <= h_in;
         end
      end
   end

   // Final scale by the angle.
   assign fin_prod = 63'(xb_ff[qs_pkg::SIN_TERMS-1]) * 63'(h_ff[qs_pkg::SIN_TERMS-1]);

   always_ff @(posedge clock) begin
      if (enable) begin
         sine_ff <= fin_prod[60:30];
      end
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire

/* sv/quaternion_slerp.sv */
`default_nettype none

// Spherical linear interpolation of two unit quaternions in signed Q1.15,
// weight in unsigned Q1.15 (values above 32768 act as 32768). The block is a
// single stall-controlled pipeline that takes one transaction every cycle
// while it is not stalled. Its depth is set by the arc cosine search (17 bit
// steps, each built around a 13-stage sine evaluator) and the 20-stage
// restoring divider (magnitude, rounding bias and overflow check, then 17
// quotient bits). When the result register holds a result that the receiver
// stalls, the whole pipeline freezes and req_stall is raised. The single
// control bit, shortest_path_enable (reset 1), negates the end quaternion
// when the dot product is negative; csr_ready is always high and the bit
// should only be written while no transaction is in flight.

`include "quaternion_slerp_defines.svh"

module quaternion_slerp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [15:0] req_weight_t,
   input  wire logic signed [15:0] req_from_q0,
   input  wire logic signed [15:0] req_from_q1,
   input  wire logic signed [15:0] req_from_q2,
   input  wire logic signed [15:0] req_from_q3,
   input  wire logic signed [15:0] req_to_q0,
   input  wire logic signed [15:0] req_to_q1,
   input  wire logic signed [15:0] req_to_q2,
   input  wire logic signed [15:0] req_to_q3,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_out_q0,
   output logic signed [15:0]      rsp_out_q1,
   output logic signed [15:0]      rsp_out_q2,
   output logic signed [15:0]      rsp_out_q3,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_shortest_path_enable
);

   localparam int SIN_LAST   = qs_pkg::SIN_LAT - 1;
   localparam int DIV_STAGES = qs_pkg::DIV_STEPS + 3;

   typedef struct packed {
      logic [15:0]      tc;
      logic [3:0][15:0] p;
      logic [3:0][16:0] q;
      logic [31:0]      c;
      logic             slerp;
      logic [16:0]      w;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic [16:0] cand;
      logic        neg;
      logic        ok;
   } step_type;

   typedef struct packed {
      logic [49:0] rem;
      logic [16:0] quo;
      logic        neg;
      logic        ovf;
   } lane_type;

   logic adv;
   logic spe_ff;

   logic signed [15:0] in_p [4];
   logic signed [15:0] in_q [4];
   logic        [15:0] tc_in;

   logic               f0_valid_ff;
   logic        [15:0] f0_tc_ff;
   logic signed [15:0] f0_p_ff [4];
   logic signed [15:0] f0_q_ff [4];
   logic signed [31:0] f0_prod_ff [4];

   logic               f1_valid_ff;
   logic        [15:0] f1_tc_ff;
   logic signed [15:0] f1_p_ff [4];
   logic signed [15:0] f1_q_ff [4];
   logic signed [33:0] f1_dot_ff;

   logic               flip;
   logic               f2_valid_ff;
   logic        [15:0] f2_tc_ff;
   logic signed [15:0] f2_p_ff [4];
   logic signed [16:0] f2_q_ff [4];
   logic signed [34:0] f2_dot_ff;

   logic signed [35:0] margin;
   item_type           item_in;

   item_type acos_item_ff  [qs_pkg::ACOS_STEPS+1];
   logic     acos_valid_ff [qs_pkg::ACOS_STEPS+1];

   logic [32:0] a1_prod;
   logic [32:0] a2_prod;
   logic        ang_valid_ff;
   item_type    ang_item_ff;
   logic [16:0] a1_ff;
   logic [16:0] a2_ff;

   logic [30:0] sin_om;
   logic [30:0] sin_a1;
   logic [30:0] sin_a2;
   item_type    sd_item_ff  [qs_pkg::SIN_LAT];
   logic        sd_valid_ff [qs_pkg::SIN_LAT];

   logic               sel;
   logic        [31:0] ka;
   logic        [31:0] kb;
   logic signed [49:0] mul_a_in [4];
   logic signed [49:0] mul_b_in [4];
   logic signed [49:0] mul_a_ff [4];
   logic signed [49:0] mul_b_ff [4];
   logic        [30:0] mul_den_ff;
   logic               mul_valid_ff;

   logic signed [49:0] num_ff [4];
   logic        [30:0] num_den_ff;
   logic               num_valid_ff;

   lane_type    div_lane_ff  [DIV_STAGES][4];
   logic [30:0] div_den_ff   [DIV_STAGES];
   logic        div_valid_ff [DIV_STAGES];

   logic signed [15:0] rsp_q_in [4];
   logic signed [15:0] rsp_q_ff [4];
   logic               rsp_valid_ff;

   // Global advance: the pipeline moves unless a held result is stalled.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // Control register write transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         spe_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         spe_ff <= csr_shortest_path_enable;
      end
   end

   // Input stage: clamp the weight and form the four products of the dot product.
   always_comb begin
      in_p[0] = req_from_q0;
      in_p[1] = req_from_q1;
      in_p[2] = req_from_q2;
      in_p[3] = req_from_q3;
      in_q[0] = req_to_q0;
      in_q[1] = req_to_q1;
      in_q[2] = req_to_q2;
      in_q[3] = req_to_q3;
      tc_in   = (req_weight_t > qs_pkg::T_ONE) ? qs_pkg::T_ONE : req_weight_t;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f0_tc_ff <= tc_in;
         for (int i = 0; i < 4; i++) begin
            f0_p_ff[i]    <= in_p[i];
            f0_q_ff[i]    <= in_q[i];
            f0_prod_ff[i] <= in_p[i] * in_q[i];
         end
      end
   end

   // Sum of the products.
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_tc_ff  <= f0_tc_ff;
         f1_p_ff   <= f0_p_ff;
         f1_q_ff   <= f0_q_ff;
         f1_dot_ff <= 34'(f0_prod_ff[0]) + 34'(f0_prod_ff[1]) +
                      34'(f0_prod_ff[2]) + 34'(f0_prod_ff[3]);
      end
   end

   // Shortest path: negate the end quaternion and the dot when negative.
   assign flip = spe_ff && f1_dot_ff[33];

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_tc_ff  <= f1_tc_ff;
         f2_p_ff   <= f1_p_ff;
         f2_dot_ff <= flip ? -35'(f1_dot_ff) : 35'(f1_dot_ff);
         for (int i = 0; i < 4; i++) begin
            f2_q_ff[i] <= flip ? -17'(f1_q_ff[i]) : 17'(f1_q_ff[i]);
         end
      end
   end

   // Choose slerp or linear weights and clamp the cosine for the search.
   always_comb begin
      margin        = 36'sd1073741824 - 36'(f2_dot_ff);
      item_in.tc    = f2_tc_ff;
      item_in.slerp = margin > 36'sd107374;
      item_in.w     = '0;
      for (int i = 0; i < 4; i++) begin
         item_in.p[i] = f2_p_ff[i];
         item_in.q[i] = f2_q_ff[i];
      end
      if (f2_dot_ff < -35'sd1073741824) begin
         item_in.c = -32'sd1073741824;
      end else if (f2_dot_ff > 35'sd1073741824) begin
         item_in.c = 32'sd1073741824;
      end else begin
         item_in.c = 32'(f2_dot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acos_item_ff[0] <= item_in;
      end
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff      <= 1'b0;
         f1_valid_ff      <= 1'b0;
         f2_valid_ff      <= 1'b0;
         acos_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         f0_valid_ff      <= req_valid;
         f1_valid_ff      <= f0_valid_ff;
         f2_valid_ff      <= f1_valid_ff;
         acos_valid_ff[0] <= f2_valid_ff;
      end
   end

   // Arc cosine by bit search, one bit per step, most significant first.
   for (genvar k = 0; k < qs_pkg::ACOS_STEPS; k++) begin : g_acos
      localparam int BIT = qs_pkg::ACOS_STEPS - 1 - k;

      step_type           prep_in;
      step_type           prep_ff;
      logic        [16:0] arg_in;
      logic        [16:0] arg_ff;
      logic               prep_valid_ff;
      logic        [30:0] sin_val;
      step_type           dly_ff       [qs_pkg::SIN_LAT];
      logic               dly_valid_ff [qs_pkg::SIN_LAT];
      logic signed [32:0] cos_pos;
      logic signed [32:0] cos_val;
      logic signed [32:0] c_ext;
      item_type           out_in;

      // Candidate angle and the sine argument that gives its cosine.
      always_comb begin
         prep_in.item = acos_item_ff[k];
         prep_in.cand = acos_item_ff[k].w | (17'd1 << BIT);
         prep_in.neg  = prep_in.cand > qs_pkg::ANG_HALF;
         prep_in.ok   = prep_in.cand <= qs_pkg::ANG_PI;
         arg_in       = prep_in.neg ? (prep_in.cand - qs_pkg::ANG_HALF) :
                                      (qs_pkg::ANG_HALF - prep_in.cand);
      end

      qs_sin u_sin (
         .clock  (clock),
         .enable (adv),
         .angle  (arg_ff),
         .sine   (sin_val)
      );

      // Keep the candidate bit when it is not above pi and its cosine is not below the target.
      always_comb begin
         cos_pos = $signed({2'b00, sin_val});
         cos_val = dly_ff[SIN_LAST].neg ? -cos_pos : cos_pos;
         c_ext   = 33'($signed(dly_ff[SIN_LAST].item.c));
         out_in  = dly_ff[SIN_LAST].item;
         if (dly_ff[SIN_LAST].ok && (cos_val >= c_ext)) begin
            out_in.w = dly_ff[SIN_LAST].cand;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            prep_ff   <= prep_in;
            arg_ff    <= arg_in;
            dly_ff[0] <= prep_ff;
            for (int i = 1; i < qs_pkg::SIN_LAT; i++) begin
               dly_ff[i] <= dly_ff[i-1];
            end
            acos_item_ff[k+1] <= out_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            prep_valid_ff <= 1'b0;
            for (int i = 0; i < qs_pkg::SIN_LAT; i++) begin
               dly_valid_ff[i] <= 1'b0;
            end
            acos_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            prep_valid_ff   <= acos_valid_ff[k];
            dly_valid_ff[0] <= prep_valid_ff;
            for (int i = 1; i < qs_pkg::SIN_LAT; i++) begin
               dly_valid_ff[i] <= dly_valid_ff[i-1];
            end
            acos_valid_ff[k+1] <= dly_valid_ff[SIN_LAST];
         end
      end
   end

   // Partial angles (1-t)w and tw, rounded.
   always_comb begin
      a1_prod = 33'(qs_pkg::T_ONE - acos_item_ff[qs_pkg::ACOS_STEPS].tc) *
                33'(acos_item_ff[qs_pkg::ACOS_STEPS].w) + 33'd16384;
      a2_prod = 33'(acos_item_ff[qs_pkg::ACOS_STEPS].tc) *
                33'(acos_item_ff[qs_pkg::ACOS_STEPS].w) + 33'd16384;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_item_ff <= acos_item_ff[qs_pkg::ACOS_STEPS];
         a1_ff       <= a1_prod[31:15];
         a2_ff       <= a2_prod[31:15];
      end
   end

   // Sines of the full and the two partial angles.
   qs_sin u_sin_om (
      .clock  (clock),
      .enable (adv),
      .angle  (ang_item_ff.w),
      .sine   (sin_om)
   );

   qs_sin u_sin_a1 (
      .clock  (clock),
      .enable (adv),
      .angle  (a1_ff),
      .sine   (sin_a1)
   );

   qs_sin u_sin_a2 (
      .clock  (clock),
      .enable (adv),
      .angle  (a2_ff),
      .sine   (sin_a2)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_item_ff[0] <= ang_item_ff;
         for (int i = 1; i < qs_pkg::SIN_LAT; i++) begin
            sd_item_ff[i] <= sd_item_ff[i-1];
         end
      end
   end

   // Weight products; a zero sine or a cosine near one falls back to linear weights.
   always_comb begin
      sel = sd_item_ff[SIN_LAST].slerp && (sin_om != '0);
      ka  = sel ? {1'b0, sin_a1} : 32'(qs_pkg::T_ONE - sd_item_ff[SIN_LAST].tc);
      kb  = sel ? {1'b0, sin_a2} : 32'(sd_item_ff[SIN_LAST].tc);
      for (int i = 0; i < 4; i++) begin
         mul_a_in[i] = $signed({1'b0, ka}) * $signed(sd_item_ff[SIN_LAST].p[i]);
         mul_b_in[i] = $signed({1'b0, kb}) * $signed(sd_item_ff[SIN_LAST].q[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_a_ff   <= mul_a_in;
         mul_b_ff   <= mul_b_in;
         mul_den_ff <= sel ? sin_om : 31'(qs_pkg::T_ONE);
      end
   end

   // Numerator sum.
   always_ff @(posedge clock) begin
      if (adv) begin
         num_den_ff <= mul_den_ff;
         for (int i = 0; i < 4; i++) begin
            num_ff[i] <= mul_a_ff[i] + mul_b_ff[i];
         end
      end
   end

   // Divider: magnitude, rounding bias, overflow check, then one bit per stage.
   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      lane_type    lane_in [4];
      logic [30:0] den_src;

      if (d == 0) begin : g_mag
         assign den_src = num_den_ff;
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               lane_in[i].neg = num_ff[i][49];
               lane_in[i].rem = num_ff[i][49] ? $unsigned(-num_ff[i]) : $unsigned(num_ff[i]);
               lane_in[i].quo = '0;
               lane_in[i].ovf = 1'b0;
            end
         end
      end else if (d == 1) begin : g_bias
         assign den_src = div_den_ff[d-1];
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               lane_in[i]     = div_lane_ff[d-1][i];
               lane_in[i].rem = div_lane_ff[d-1][i].rem + 50'(div_den_ff[d-1] >> 1);
            end
         end
      end else if (d == 2) begin : g_ovf
         assign den_src = div_den_ff[d-1];
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               lane_in[i]     = div_lane_ff[d-1][i];
               lane_in[i].ovf = div_lane_ff[d-1][i].rem >=
                                (50'(div_den_ff[d-1]) << qs_pkg::DIV_STEPS);
            end
         end
      end else begin : g_step
         localparam int QB = qs_pkg::DIV_STEPS - 1 - (d - 3);
         logic [49:0] dsh;
         assign den_src = div_den_ff[d-1];
         assign dsh     = 50'(div_den_ff[d-1]) << QB;
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               lane_in[i] = div_lane_ff[d-1][i];
               if (div_lane_ff[d-1][i].rem >= dsh) begin
                  lane_in[i].rem     = div_lane_ff[d-1][i].rem - dsh;
                  lane_in[i].quo[QB] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_den_ff[d] <= den_src;
            for (int i = 0; i < 4; i++) begin
               div_lane_ff[d][i] <= lane_in[i];
            end
         end
      end
   end

   // Saturate to signed Q1.15.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (div_lane_ff[DIV_STAGES-1][i].neg) begin
            rsp_q_in[i] = (div_lane_ff[DIV_STAGES-1][i].ovf ||
                           (div_lane_ff[DIV_STAGES-1][i].quo > 17'd32768)) ?
                          16'sh8000 : 16'(-div_lane_ff[DIV_STAGES-1][i].quo);
         end else begin
            rsp_q_in[i] = (div_lane_ff[DIV_STAGES-1][i].ovf ||
                           (div_lane_ff[DIV_STAGES-1][i].quo > 17'd32767)) ?
                          16'sh7FFF : 16'(div_lane_ff[DIV_STAGES-1][i].quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_q_ff <= rsp_q_in;
      end
   end

   // Valid bits of the back stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         ang_valid_ff <= 1'b0;
         for (int i = 0; i < qs_pkg::SIN_LAT; i++) begin
            sd_valid_ff[i] <= 1'b0;
         end
         mul_valid_ff <= 1'b0;
         num_valid_ff <= 1'b0;
         for (int i = 0; i < DIV_STAGES; i++) begin
            div_valid_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         ang_valid_ff   <= acos_valid_ff[qs_pkg::ACOS_STEPS];
         sd_valid_ff[0] <= ang_valid_ff;
         for (int i = 1; i < qs_pkg::SIN_LAT; i++) begin
            sd_valid_ff[i] <= sd_valid_ff[i-1];
         end
         mul_valid_ff    <= sd_valid_ff[SIN_LAST];
         num_valid_ff    <= mul_valid_ff;
         div_valid_ff[0] <= num_valid_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            div_valid_ff[i] <= div_valid_ff[i-1];
         end
         rsp_valid_ff <= div_valid_ff[DIV_STAGES-1];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_q0 = rsp_q_ff[0];
   assign rsp_out_q1 = rsp_q_ff[1];
   assign rsp_out_q2 = rsp_q_ff[2];
   assign rsp_out_q3 = rsp_q_ff[3];

   // A finished division moves into the result register on advance.
   `QS_ASSERT_NEXT(a_rsp_follows_div, clock, reset, adv && div_valid_ff[DIV_STAGES-1], rsp_valid_ff)
   // The searched angle never exceeds pi.
   `QS_ASSERT_IMPLIES(a_acos_range, clock, reset, acos_valid_ff[qs_pkg::ACOS_STEPS], acos_item_ff[qs_pkg::ACOS_STEPS].w <= qs_pkg::ANG_PI)
   // The divisor chosen for an item is never zero.
   `QS_ASSERT_IMPLIES(a_den_nonzero, clock, reset, mul_valid_ff, mul_den_ff != '0)
   // A stalled pipeline keeps the valid bit at the end of the arc cosine search.
   `QS_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(acos_valid_ff[qs_pkg::ACOS_STEPS]))

endmodule

`default_nettype wire

/* dv/tb_quaternion_slerp.sv */
`timescale 1ns / 1ps

module tb_quaternion_slerp;

   localparam int LATENCY   = 296;
   localparam int NUM_RAND  = 900;
   localparam longint ONE30 = 64'sd1073741824;
   localparam longint EPS30 = 64'sd107374;

   // One input transaction.
   typedef struct packed {
      logic [15:0]        weight;
      logic signed [15:0] p0, p1, p2, p3;
      logic signed [15:0] q0, q1, q2, q3;
   } slerp_req_type;

   typedef struct packed {
      logic signed [15:0] r0, r1, r2, r3;
   } slerp_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_weight_t = '0;
   logic signed [15:0] req_from_q0 = '0, req_from_q1 = '0, req_from_q2 = '0;
   logic signed [15:0] req_from_q3 = '0;
   logic signed [15:0] req_to_q0 = '0, req_to_q1 = '0, req_to_q2 = '0;
   logic signed [15:0] req_to_q3 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_out_q0, rsp_out_q1, rsp_out_q2, rsp_out_q3;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_shortest_path_enable = 1'b1;

   slerp_req_type pending_reqs[$];
   slerp_rsp_type expected_quats[$];
   bit shortest_path = 1'b1;
   bit quiet_mode = 1'b0;
   int error_count = 0;

   quaternion_slerp DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Polynomial sine of an angle with pi = 65536, result in Q.30.
   function automatic longint sine_q30(input longint ang);
      longint unsigned x, x2, h, tmp;
      longint unsigned divs[5];
      longint a;
      divs = '{110, 72, 42, 20, 6};
      a = ang;
      if (a > 65536) a = 65536;
      if (a > 32768) a = 65536 - a;
      x = (longint'(a) * 64'd3373259426) >> 16;
      x2 = (x * x) >> 30;
      h = ONE30;
      for (int i = 0; i < 5; i++) begin
         tmp = ((x2 * h) >> 30) / divs[i];
         h = (tmp > ONE30) ? 0 : ONE30 - tmp;
      end
      return longint'((x * h) >> 30);
   endfunction

   function automatic longint cosine_q30(input longint a);
      if (a <= 32768) return sine_q30(32768 - a);
      return -sine_q30(a - 32768);
   endfunction

   // Bitwise search for the angle whose cosine matches c.
   function automatic longint arc_cosine(input longint c);
      longint w, cand;
      w = 0;
      for (int b = 16; b >= 0; b--) begin
         cand = w | (64'sd1 << b);
         if (cand <= 65536 && cosine_q30(cand) >= c) w = cand;
      end
      return w;
   endfunction

   function automatic logic signed [15:0] round_saturate(input longint num,
                                                          input longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + (den >>> 1)) / den;
      if (num < 0) return (q > 32768) ? -16'sd32768 : 16'(-q);
      return (q > 32767) ? 16'sd32767 : 16'(q);
   endfunction

   // Works out the interpolated quaternion for one transaction.
   function automatic slerp_rsp_type interpolate(input slerp_req_type r);
      longint p[4], q[4], dot, t, w, sin_w, s1, s2, c;
      logic signed [15:0] res[4];
      bit linear;
      t = (r.weight > 32768) ? 32768 : r.weight;
      p = '{r.p0, r.p1, r.p2, r.p3};
      q = '{r.q0, r.q1, r.q2, r.q3};
      dot = 0;
      for (int i = 0; i < 4; i++) dot += p[i] * q[i];
      if (shortest_path && dot < 0) begin
         dot = -dot;
         for (int i = 0; i < 4; i++) q[i] = -q[i];
      end
      linear = 1'b1;
      sin_w = 0; s1 = 0; s2 = 0;
      if (ONE30 - dot > EPS30) begin
         c = (dot < -ONE30) ? -ONE30 : dot;
         w = arc_cosine(c);
         sin_w = sine_q30(w);
         if (sin_w > 0) begin
            linear = 1'b0;
            s1 = sine_q30(((32768 - t) * w + 16384) >> 15);
            s2 = sine_q30((t * w + 16384) >> 15);
         end
      end
      for (int i = 0; i < 4; i++)
         res[i] = linear ? round_saturate((32768 - t) * p[i] + t * q[i], 32768)
                         : round_saturate(s1 * p[i] + s2 * q[i], sin_w);
      return '{res[0], res[1], res[2], res[3]};
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Random pair of unit quaternions made from random directions, with a random weight.
   function automatic slerp_req_type random_unit_pair(input bit near);
      slerp_req_type r;
      real a[4], b[4], n, m;
      n = 0; m = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = real'($urandom_range(2000)) - 1000.0;
         b[i] = near ? a[i] + real'($urandom_range(20)) - 10.0
                     : real'($urandom_range(2000)) - 1000.0;
         n += a[i] * a[i];
         m += b[i] * b[i];
      end
      n = $sqrt(n) + 1e-9; m = $sqrt(m) + 1e-9;
      if ($urandom_range(1)) m = -m;
      r.weight = 16'($urandom_range(32768));
      r.p0 = 16'($rtoi(a[0] / n * 32767.0)); r.p1 = 16'($rtoi(a[1] / n * 32767.0));
      r.p2 = 16'($rtoi(a[2] / n * 32767.0)); r.p3 = 16'($rtoi(a[3] / n * 32767.0));
      r.q0 = 16'($rtoi(b[0] / m * 32767.0)); r.q1 = 16'($rtoi(b[1] / m * 32767.0));
      r.q2 = 16'($rtoi(b[2] / m * 32767.0)); r.q3 = 16'($rtoi(b[3] / m * 32767.0));
      return r;
   endfunction

   function automatic slerp_req_type random_noise();
      slerp_req_type r;
      r = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      return r;
   endfunction

   // Driver: presents pending transactions with random idle cycles outside quiet mode.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (pending_reqs.size() > 0 && (quiet_mode || $urandom_range(99) >= 36)) begin
            slerp_req_type r;
            r = pending_reqs.pop_front();
            expected_quats.push_back(interpolate(r));
            req_valid <= 1'b1;
            {req_weight_t, req_from_q0, req_from_q1, req_from_q2, req_from_q3,
             req_to_q0, req_to_q1, req_to_q2, req_to_q3} <= r;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Random stalls on the result side outside quiet mode.
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : (!quiet_mode && $urandom_range(99) < 36);
   end

   // Monitor: checks each result transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quats.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            slerp_rsp_type e;
            e = expected_quats.pop_front();
            if (rsp_out_q0 !== e.r0) report_mismatch("out_q0", rsp_out_q0, e.r0);
            if (rsp_out_q1 !== e.r1) report_mismatch("out_q1", rsp_out_q1, e.r1);
            if (rsp_out_q2 !== e.r2) report_mismatch("out_q2", rsp_out_q2, e.r2);
            if (rsp_out_q3 !== e.r3) report_mismatch("out_q3", rsp_out_q3, e.r3);
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || expected_quats.size() > 0 || req_valid)
         @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   task automatic write_shortest_path(input bit v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_shortest_path_enable <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shortest_path = v;
   endtask

   task automatic add_directed();
      slerp_req_type r;
      r = '{16'd0, 16'sd32767, '0, '0, '0, '0, 16'sd32767, '0, '0};
      pending_reqs.push_back(r);
      r.weight = 16'd32768; pending_reqs.push_back(r);
      r.weight = 16'hFFFF; pending_reqs.push_back(r);
      r.weight = 16'd16384; pending_reqs.push_back(r);
      // Positive dot product, the end quaternion at an angle of pi/4.
      r = '{16'd16384, 16'sd32767, '0, '0, '0, 16'sd23170, -16'sd23170, '0, '0};
      pending_reqs.push_back(r);
      // Antipodal quaternions.
      r = '{16'd10000, 16'sd32767, '0, '0, '0, -16'sd32767, '0, '0, '0};
      pending_reqs.push_back(r);
      // Identical inputs take the linear path.
      r = '{16'd20000, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
            16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
      pending_reqs.push_back(r);
      // Non-unit inputs with the dot above one and below minus one.
      r = '{16'd8000, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
            -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
      pending_reqs.push_back(r);
      r = '{16'd8000, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
            16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
      pending_reqs.push_back(r);
      r = '{16'd32768, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
            -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
      pending_reqs.push_back(r);
      r = '{16'd1, '0, '0, '0, '0, '0, '0, '0, '0};
      pending_reqs.push_back(r);
      r = '{16'd32767, 16'sd32767, '0, '0, '0, '0, '0, '0, -16'sd32768};
      pending_reqs.push_back(r);
   endtask

   task automatic add_random(input int n);
      slerp_req_type r;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0, 1: r = random_noise();
            2:    r = random_unit_pair(1'b1);
            default: r = random_unit_pair(1'b0);
         endcase
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // Default setting, then both explicit settings.
      add_directed();
      add_random(250);
      wait_drained();
      write_shortest_path(1'b0);
      add_directed();
      add_random(250);
      wait_drained();
      // Stretch with no idling on either side.
      write_shortest_path(1'b1);
      quiet_mode = 1'b1;
      add_random(150);
      wait_drained();
      quiet_mode = 1'b0;
      add_random(NUM_RAND - 650);
      wait_drained();
      if (error_count == 0)
         $display("[quaternion_slerp] OK");
      else
         $display("[quaternion_slerp] ERROR");
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("[quaternion_slerp] ERROR");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/qs_pkg.sv
sv/qs_sin.sv
sv/quaternion_slerp.sv
dv/tb_quaternion_slerp.sv
